@@ src/jpeg_header_format_classifier_assert.svh @@
// assertion macros for the jpeg header classifier
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef JPEG_HEADER_FORMAT_CLASSIFIER_ASSERT_SVH
`define JPEG_HEADER_FORMAT_CLASSIFIER_ASSERT_SVH

// condition must hold at every clock edge outside reset
`define JHFC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define JHFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/jhfc_pkg.sv @@
// types, codes and tag tables for the jpeg header classifier
// no dependencies
`timescale 1ns / 1ps

package jhfc_pkg;

    typedef enum logic [5:0] {
        PH_SEARCH  = 6'b000001,
        PH_PREFIX  = 6'b000010,
        PH_LEN_HI  = 6'b000100,
        PH_LEN_LO  = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_DONE    = 6'b100000
    } t_phase;

    localparam logic [7:0] c_MK_FILL  = 8'hFF;
    localparam logic [7:0] c_MK_STUFF = 8'h00;
    localparam logic [7:0] c_MK_TEM   = 8'h01;
    localparam logic [7:0] c_MK_RST0  = 8'hD0;
    localparam logic [7:0] c_MK_SOI   = 8'hD8;
    localparam logic [7:0] c_MK_EOI   = 8'hD9;
    localparam logic [7:0] c_MK_SOS   = 8'hDA;
    localparam logic [7:0] c_MK_APP0  = 8'hE0;
    localparam logic [7:0] c_MK_APP14 = 8'hEE;
    localparam logic [7:0] c_MK_SOF0  = 8'hC0;
    localparam logic [7:0] c_MK_SOF15 = 8'hCF;
    localparam logic [7:0] c_MK_DHT   = 8'hC4;
    localparam logic [7:0] c_MK_DAC   = 8'hCC;

    localparam logic [15:0] c_TAG_LEN       = 16'd5;
    localparam logic [15:0] c_XFORM_POS     = 16'd11;
    localparam logic [15:0] c_FRAME_HDR_LEN = 16'd6;
    localparam logic [7:0]  c_MAX_COMPS     = 8'd4;
    localparam logic [3:0]  c_MAX_FACTOR    = 4'd4;
    localparam logic [7:0]  c_MAX_TQ        = 8'd3;

    localparam logic [7:0] c_ID_R = 8'h52;
    localparam logic [7:0] c_ID_G = 8'h47;
    localparam logic [7:0] c_ID_B = 8'h42;

    localparam logic [7:0] c_SAMP_11 = 8'h11;
    localparam logic [7:0] c_SAMP_21 = 8'h21;
    localparam logic [7:0] c_SAMP_22 = 8'h22;

    localparam logic [1:0] c_CS_UNKNOWN = 2'd0;
    localparam logic [1:0] c_CS_GRAY    = 2'd1;
    localparam logic [1:0] c_CS_YCC     = 2'd2;
    localparam logic [1:0] c_CS_RGB     = 2'd3;

    localparam logic [2:0] c_SK_UNKNOWN = 3'd0;
    localparam logic [2:0] c_SK_GRAY    = 3'd1;
    localparam logic [2:0] c_SK_420     = 3'd2;
    localparam logic [2:0] c_SK_422     = 3'd3;
    localparam logic [2:0] c_SK_444     = 3'd4;
    localparam logic [2:0] c_SK_RGB     = 3'd5;
    localparam logic [2:0] c_SK_BGR     = 3'd6;

    // "JFIF" followed by a nul
    function automatic logic [7:0] jfif_tag(input logic [2:0] idx);
        logic [7:0] v;
        unique case (idx)
            3'd0:    v = 8'h4A;
            3'd1:    v = 8'h46;
            3'd2:    v = 8'h49;
            3'd3:    v = 8'h46;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // five byte identifier of the app14 segment
    function automatic logic [7:0] app14_tag(input logic [2:0] idx);
        logic [7:0] v;
        unique case (idx)
            3'd0:    v = 8'h41;
            3'd1:    v = 8'h64;
            3'd2:    v = 8'h6F;
            3'd3:    v = 8'h62;
            default: v = 8'h65;
        endcase
        return v;
    endfunction

    function automatic logic is_sof(input logic [7:0] m);
        return (m >= c_MK_SOF0) && (m <= c_MK_SOF15) && (m != c_MK_DHT) && (m != c_MK_DAC);
    endfunction

endpackage

@@ src/jpeg_header_format_classifier.sv @@
// jpeg header classifier: marker walk, frame header capture and classification
// depends on jhfc_pkg and jpeg_header_format_classifier_assert.svh
//
// usage
//   input channel: one buffer byte per word (i_data_byte), i_last_byte on the
//   final byte of the buffer; a word moves when i_valid is high and o_stall low
//   output channel: one result word per buffer on o_valid / i_stall, the
//   fields held steady while i_stall is high
//   throughput: one byte per cycle while o_stall is low; each byte updates the
//   parser state in the cycle it is taken, so the state registers set the rate
//   the result word shows o_valid in the cycle after the byte that ends the
//   walk (sos, eoi, a complete frame header, a bad length or the last byte)
//   bytes after the end of the walk up to i_last_byte are dropped; the last
//   byte clears all parser state for the next buffer
//   reset: synchronous, active low; the parser returns to marker search and
//   the output register empties
//   stall: o_stall is high only while a result word waits and i_stall is high
`timescale 1ns / 1ps
`include "jpeg_header_format_classifier_assert.svh"

module jpeg_header_format_classifier
    import jhfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_info_valid,
    output logic        o_size_valid,
    output logic [15:0] o_image_width,
    output logic [15:0] o_image_height,
    output logic [3:0]  o_sof_type,
    output logic [2:0]  o_component_count,
    output logic [1:0]  o_colour_space,
    output logic [2:0]  o_sampling_kind
);

    // parser state
    t_phase      r_phase, p_phase, n_phase;
    logic [7:0]  r_marker, p_marker, n_marker;
    logic [15:0] r_seg_rem, p_seg_rem, n_seg_rem;
    logic [15:0] r_seg_pos, p_seg_pos, n_seg_pos;
    logic [2:0]  r_comp_idx, p_comp_idx, n_comp_idx;
    logic [1:0]  r_comp_sub, p_comp_sub, n_comp_sub;
    logic        r_ident, p_ident, n_ident;
    logic        r_jfif, p_jfif, n_jfif;
    logic        r_xf_seen, p_xf_seen, n_xf_seen;
    logic [7:0]  r_xf_val, p_xf_val, n_xf_val;
    logic [15:0] r_width, p_width, n_width;
    logic [15:0] r_height, p_height, n_height;
    logic [7:0]  r_ncomp, p_ncomp, n_ncomp;
    logic [7:0]  r_cid [3];
    logic [7:0]  p_cid [3];
    logic [7:0]  n_cid [3];
    logic [7:0]  r_cfac [3];
    logic [7:0]  p_cfac [3];
    logic [7:0]  n_cfac [3];
    logic        r_bad, p_bad, n_bad;

    // output register
    logic        r_out_valid;
    logic        r_out_info, r_out_dims;
    logic [15:0] r_out_width, r_out_height;
    logic [3:0]  r_out_sof;
    logic [2:0]  r_out_ncomp;
    logic [1:0]  r_out_cs;
    logic [2:0]  r_out_sk;

    logic        in_acc, out_acc;
    logic        p_emit, p_ok, emit_now;
    logic [15:0] len_full;
    logic [7:0]  tag_byte;
    logic        tag_hit;
    logic [3:0]  need_len;
    logic        is_rgb, is_bgr, use_ycc;
    logic [2:0]  ycc_sk;
    logic [1:0]  cls_cs;
    logic [2:0]  cls_sk;

    assign o_stall = r_out_valid & i_stall;
    assign in_acc  = i_valid & ~o_stall;
    assign out_acc = r_out_valid & ~i_stall;

    // one byte of the marker walk
    always_comb begin
        p_phase    = r_phase;
        p_marker   = r_marker;
        p_seg_rem  = r_seg_rem;
        p_seg_pos  = r_seg_pos;
        p_comp_idx = r_comp_idx;
        p_comp_sub = r_comp_sub;
        p_ident    = r_ident;
        p_jfif     = r_jfif;
        p_xf_seen  = r_xf_seen;
        p_xf_val   = r_xf_val;
        p_width    = r_width;
        p_height   = r_height;
        p_ncomp    = r_ncomp;
        p_cid      = r_cid;
        p_cfac     = r_cfac;
        p_bad      = r_bad;
        p_emit     = 1'b0;
        p_ok       = 1'b0;
        len_full   = {r_seg_rem[15:8], i_data_byte};
        tag_byte   = (r_marker == c_MK_APP0) ? jfif_tag(r_seg_pos[2:0])
                                             : app14_tag(r_seg_pos[2:0]);
        tag_hit    = ((r_seg_pos == 16'd0) | r_ident) & (i_data_byte == tag_byte);
        unique case (r_phase)
            PH_SEARCH: begin
                if (i_data_byte == c_MK_FILL) p_phase = PH_PREFIX;
            end
            PH_PREFIX: begin
                if (i_data_byte == c_MK_FILL) begin
                    p_phase = PH_PREFIX;
                end else if (i_data_byte == c_MK_STUFF) begin
                    p_phase = PH_SEARCH;
                end else if (i_data_byte == c_MK_EOI || i_data_byte == c_MK_SOS) begin
                    p_emit  = 1'b1;
                    p_phase = PH_DONE;
                end else if (i_data_byte == c_MK_TEM ||
                             (i_data_byte >= c_MK_RST0 && i_data_byte <= c_MK_SOI)) begin
                    p_phase = PH_SEARCH;
                end else begin
                    p_marker = i_data_byte;
                    p_phase  = PH_LEN_HI;
                end
            end
            PH_LEN_HI: begin
                p_seg_rem = {i_data_byte, 8'h00};
                p_phase   = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                if (len_full < 16'd2) begin
                    p_emit  = 1'b1;
                    p_phase = PH_DONE;
                end else begin
                    p_seg_rem  = len_full - 16'd2;
                    p_seg_pos  = 16'd0;
                    p_ident    = 1'b0;
                    p_comp_idx = 3'd0;
                    p_comp_sub = 2'd0;
                    if (is_sof(r_marker)) begin
                        p_bad    = 1'b0;
                        p_width  = 16'd0;
                        p_height = 16'd0;
                        p_ncomp  = 8'd0;
                    end
                    p_phase = (p_seg_rem == 16'd0) ? PH_SEARCH : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (r_marker == c_MK_APP0 || r_marker == c_MK_APP14) begin
                    if (r_seg_pos < c_TAG_LEN) begin
                        p_ident = tag_hit;
                        if (r_seg_pos == 16'd4 && tag_hit && r_marker == c_MK_APP0)
                            p_jfif = 1'b1;
                    end else if (r_seg_pos == c_XFORM_POS && r_ident &&
                                 r_marker == c_MK_APP14) begin
                        p_xf_seen = 1'b1;
                        p_xf_val  = i_data_byte;
                    end
                end else if (is_sof(r_marker)) begin
                    case (r_seg_pos)
                        16'd1:   p_height = {i_data_byte, 8'h00};
                        16'd2:   p_height = {r_height[15:8], i_data_byte};
                        16'd3:   p_width  = {i_data_byte, 8'h00};
                        16'd4:   p_width  = {r_width[15:8], i_data_byte};
                        16'd5:   p_ncomp  = i_data_byte;
                        default: ;
                    endcase
                    // component records: id, factors, table selector
                    if (r_seg_pos >= c_FRAME_HDR_LEN && r_comp_idx < 3'd4) begin
                        if ({5'd0, r_comp_idx} < r_ncomp) begin
                            case (r_comp_sub)
                                2'd0: begin
                                    if (r_comp_idx < 3'd3) p_cid[r_comp_idx[1:0]] = i_data_byte;
                                end
                                2'd1: begin
                                    if (i_data_byte[7:4] > c_MAX_FACTOR ||
                                        i_data_byte[3:0] > c_MAX_FACTOR)
                                        p_bad = 1'b1;
                                    if (r_comp_idx < 3'd3)
                                        p_cfac[r_comp_idx[1:0]] = i_data_byte;
                                end
                                default: begin
                                    if (i_data_byte > c_MAX_TQ) p_bad = 1'b1;
                                end
                            endcase
                        end
                        if (r_comp_sub == 2'd2) begin
                            p_comp_sub = 2'd0;
                            p_comp_idx = r_comp_idx + 3'd1;
                        end else begin
                            p_comp_sub = r_comp_sub + 2'd1;
                        end
                    end
                end
                p_seg_pos = r_seg_pos + 16'd1;
                p_seg_rem = r_seg_rem - 16'd1;
                p_phase   = (p_seg_rem == 16'd0) ? PH_SEARCH : PH_PAYLOAD;
            end
            PH_DONE: begin
                p_phase = PH_DONE;
            end
            default: begin
                p_phase = PH_SEARCH;
            end
        endcase

        // segment end: a frame header closes the walk
        need_len = {p_ncomp[2:0], 1'b0} + {1'b0, p_ncomp[2:0]};
        if ((r_phase == PH_LEN_LO || r_phase == PH_PAYLOAD) && !p_emit &&
            p_seg_rem == 16'd0 && is_sof(r_marker)) begin
            p_emit  = 1'b1;
            p_phase = PH_DONE;
            p_ok    = ~(p_bad | (p_seg_pos < c_FRAME_HDR_LEN) | (p_ncomp > c_MAX_COMPS) |
                        ((p_seg_pos - c_FRAME_HDR_LEN) < {12'd0, need_len}));
        end
    end

    // classification from the captured frame header
    always_comb begin
        is_rgb = (p_cid[0] == c_ID_R) && (p_cid[1] == c_ID_G) && (p_cid[2] == c_ID_B);
        is_bgr = (p_cid[0] == c_ID_B) && (p_cid[1] == c_ID_G) && (p_cid[2] == c_ID_R);
        if (p_xf_seen && p_xf_val == 8'd1)      use_ycc = 1'b1;
        else if (p_xf_seen && p_xf_val == 8'd0) use_ycc = 1'b0;
        else if (p_jfif)                        use_ycc = 1'b1;
        else                                    use_ycc = ~(is_rgb | is_bgr);
        ycc_sk = c_SK_UNKNOWN;
        if (p_cfac[1] == c_SAMP_11 && p_cfac[2] == c_SAMP_11) begin
            if (p_cfac[0] == c_SAMP_22)      ycc_sk = c_SK_420;
            else if (p_cfac[0] == c_SAMP_21) ycc_sk = c_SK_422;
            else if (p_cfac[0] == c_SAMP_11) ycc_sk = c_SK_444;
        end
        cls_cs = c_CS_UNKNOWN;
        cls_sk = c_SK_UNKNOWN;
        if (p_ncomp == 8'd1) begin
            cls_cs = c_CS_GRAY;
            cls_sk = c_SK_GRAY;
        end else if (p_ncomp == 8'd3) begin
            if (use_ycc) begin
                cls_sk = ycc_sk;
                if (ycc_sk != c_SK_UNKNOWN) cls_cs = c_CS_YCC;
            end else if (is_rgb) begin
                cls_cs = c_CS_RGB;
                cls_sk = c_SK_RGB;
            end else if (is_bgr) begin
                cls_cs = c_CS_RGB;
                cls_sk = c_SK_BGR;
            end
        end
    end

    // last byte of the buffer: a walk still open reports invalid, then all clears
    always_comb begin
        emit_now = p_emit | (i_last_byte & (p_phase != PH_DONE));
        if (i_last_byte) begin
            n_phase    = PH_SEARCH;
            n_marker   = 8'd0;
            n_seg_rem  = 16'd0;
            n_seg_pos  = 16'd0;
            n_comp_idx = 3'd0;
            n_comp_sub = 2'd0;
            n_ident    = 1'b0;
            n_jfif     = 1'b0;
            n_xf_seen  = 1'b0;
            n_xf_val   = 8'd0;
            n_width    = 16'd0;
            n_height   = 16'd0;
            n_ncomp    = 8'd0;
            n_cid      = '{default: 8'd0};
            n_cfac     = '{default: 8'd0};
            n_bad      = 1'b0;
        end else begin
            n_phase    = p_phase;
            n_marker   = p_marker;
            n_seg_rem  = p_seg_rem;
            n_seg_pos  = p_seg_pos;
            n_comp_idx = p_comp_idx;
            n_comp_sub = p_comp_sub;
            n_ident    = p_ident;
            n_jfif     = p_jfif;
            n_xf_seen  = p_xf_seen;
            n_xf_val   = p_xf_val;
            n_width    = p_width;
            n_height   = p_height;
            n_ncomp    = p_ncomp;
            n_cid      = p_cid;
            n_cfac     = p_cfac;
            n_bad      = p_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SEARCH;
            r_marker   <= 8'd0;
            r_seg_rem  <= 16'd0;
            r_seg_pos  <= 16'd0;
            r_comp_idx <= 3'd0;
            r_comp_sub <= 2'd0;
            r_ident    <= 1'b0;
            r_jfif     <= 1'b0;
            r_xf_seen  <= 1'b0;
            r_xf_val   <= 8'd0;
            r_width    <= 16'd0;
            r_height   <= 16'd0;
            r_ncomp    <= 8'd0;
            r_cid      <= '{default: 8'd0};
            r_cfac     <= '{default: 8'd0};
            r_bad      <= 1'b0;
        end else if (in_acc) begin
            r_phase    <= n_phase;
            r_marker   <= n_marker;
            r_seg_rem  <= n_seg_rem;
            r_seg_pos  <= n_seg_pos;
            r_comp_idx <= n_comp_idx;
            r_comp_sub <= n_comp_sub;
            r_ident    <= n_ident;
            r_jfif     <= n_jfif;
            r_xf_seen  <= n_xf_seen;
            r_xf_val   <= n_xf_val;
            r_width    <= n_width;
            r_height   <= n_height;
            r_ncomp    <= n_ncomp;
            r_cid      <= n_cid;
            r_cfac     <= n_cfac;
            r_bad      <= n_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && emit_now) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    // invalid results are all zero
    always_ff @(posedge i_clk) begin
        if (in_acc && emit_now) begin
            r_out_info   <= p_ok & (cls_sk != c_SK_UNKNOWN);
            r_out_dims   <= p_ok & (p_width != 16'd0) & (p_height != 16'd0);
            r_out_width  <= p_ok ? p_width : 16'd0;
            r_out_height <= p_ok ? p_height : 16'd0;
            r_out_sof    <= p_ok ? p_marker[3:0] : 4'd0;
            r_out_ncomp  <= p_ok ? p_ncomp[2:0] : 3'd0;
            r_out_cs     <= p_ok ? cls_cs : c_CS_UNKNOWN;
            r_out_sk     <= p_ok ? cls_sk : c_SK_UNKNOWN;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_info_valid      = r_out_info;
    assign o_size_valid      = r_out_dims;
    assign o_image_width     = r_out_width;
    assign o_image_height    = r_out_height;
    assign o_sof_type        = r_out_sof;
    assign o_component_count = r_out_ncomp;
    assign o_colour_space    = r_out_cs;
    assign o_sampling_kind   = r_out_sk;

    `JHFC_ASSERT_NEXT(a_last_gives_word, in_acc && i_last_byte && r_phase != PH_DONE, o_valid, "open walk at last byte gave no result word")
    `JHFC_ASSERT_NEXT(a_last_clears, in_acc && i_last_byte, r_phase == PH_SEARCH && !r_jfif && !r_xf_seen, "last byte did not clear parser state")
    `JHFC_ASSERT_ALWAYS(a_info_matches_kind, !o_valid || (o_info_valid == (o_sampling_kind != c_SK_UNKNOWN)), "info flag disagrees with sampling kind")
    `JHFC_ASSERT_ALWAYS(a_rgb_three_comps, !(o_valid && o_colour_space == c_CS_RGB) || o_component_count == 3'd3, "rgb result without three components")

endmodule
